>>> hdl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: list capacity,
// index widths, request codes and the element store write beat.
// ----------------------------------------------------------------------------
package ple_pkg;

    // List capacity and widths
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 6;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;

    // Request codes
    localparam logic [1:0] REQ_GET    = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_INSERT = 2'd2;
    localparam logic [1:0] REQ_DELETE = 2'd3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] word_t;

    // One write beat into the element store
    typedef struct packed {
        logic  en;
        idx_t  addr;
        word_t data;
    } mem_wr_t;

endpackage

>>> hdl/ple_store.sv
// ----------------------------------------------------------------------------
// ple_store
// Element store: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module ple_store (
    input  logic            clk,
    input  ple_pkg::mem_wr_t wr,
    input  ple_pkg::idx_t   rd_addr,
    output ple_pkg::word_t  rd_data
);
    import ple_pkg::*;

    word_t mem [CAPACITY];

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY signed 32-bit values with get, find, insert
// and delete-range requests.
// ----------------------------------------------------------------------------
// One request is worked at a time; the input is ready only while the engine
// is idle, and a finished result waits in the output register so the next
// request can be taken before it is drained. All elements sit in a single
// one-port-read, one-port-write store with registered read data, and the
// engine walks it one element per cycle. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module positional_list_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              req_type,
    input  logic [ple_pkg::POS_W-1:0] position,
    input  logic signed [31:0]      value,
    input  logic signed [31:0]      range_low,
    input  logic signed [31:0]      range_high,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    status_ok,
    output logic signed [31:0]      read_value,
    output logic [ple_pkg::CNT_W-1:0] found_position,
    output logic [ple_pkg::CNT_W-1:0] list_length
);
    import ple_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GET  = 3'd1;
    localparam logic [2:0] S_FIND = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_DEL  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]  state_reg, state_next;
    cnt_t        count_reg, count_next;
    cnt_t        idx_reg, idx_next;
    cnt_t        kept_reg, kept_next;
    logic        pend_reg, pend_next;
    idx_t        pend_idx_reg, pend_idx_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    word_t       val_reg, val_next;
    word_t       lo_reg, lo_next;
    word_t       hi_reg, hi_next;
    logic        res_ok_reg, res_ok_next;
    word_t       res_rd_reg, res_rd_next;
    cnt_t        res_found_reg, res_found_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_load;

    mem_wr_t     wr;
    idx_t        rd_addr;
    word_t       rd_data;

    logic [POS_W-1:0] pos_m1;
    logic [POS_W-1:0] in_pos_m1;
    logic [CNT_W:0]   count_p1;
    logic             get_ok;
    logic             ins_ok;
    logic             in_range;
    cnt_t             idx_m1;

    ple_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    assign in_pos_m1 = position - POS_W'(1);
    assign pos_m1    = pos_reg - POS_W'(1);
    assign idx_m1    = idx_reg - CNT_W'(1);
    assign count_p1  = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign get_ok    = (position != '0) && (position <= count_reg);
    assign ins_ok    = (position != '0) && ({1'b0, position} <= count_p1)
                       && (count_reg < CNT_W'(CAPACITY));
    assign in_range  = ($signed(lo_reg) < $signed(rd_data))
                       && ($signed(rd_data) < $signed(hi_reg));

    // Pick the store read address for the current state
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = in_pos_m1[IDX_W-1:0];
            S_INS:   rd_addr = idx_m1[IDX_W-1:0];
            default: rd_addr = idx_reg[IDX_W-1:0];
        endcase
    end

    // Sequence one request over the store
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_ok_next    = res_ok_reg;
        res_rd_next    = res_rd_reg;
        res_found_next = res_found_reg;
        out_load       = 1'b0;
        wr.en          = 1'b0;
        wr.addr        = '0;
        wr.data        = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next       = position;
                    val_next       = value;
                    lo_next        = range_low;
                    hi_next        = range_high;
                    res_rd_next    = '0;
                    res_found_next = '0;
                    idx_next       = '0;
                    kept_next      = '0;
                    unique case (req_type)
                        REQ_GET:
                        begin
                            res_ok_next = get_ok;
                            state_next  = get_ok ? S_GET : S_DONE;
                        end
                        REQ_FIND:
                        begin
                            res_ok_next = 1'b1;
                            state_next  = S_FIND;
                        end
                        REQ_INSERT:
                        begin
                            res_ok_next = ins_ok;
                            idx_next    = count_reg;
                            state_next  = ins_ok ? S_INS : S_DONE;
                        end
                        default:
                        begin
                            res_ok_next = 1'b1;
                            state_next  = S_DEL;
                        end
                    endcase
                end
            end

            S_GET:
            begin
                res_rd_next = rd_data;
                state_next  = S_DONE;
            end

            S_FIND:
            begin
                // Compare the element read last cycle, issue the next read
                if (pend_reg && (rd_data == val_reg))
                begin
                    res_found_next = CNT_W'(pend_idx_reg) + CNT_W'(1);
                    state_next     = S_DONE;
                end
                else if (idx_reg == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
            end

            S_INS:
            begin
                // Move the element read last cycle up by one slot
                if (pend_reg)
                begin
                    wr.en   = 1'b1;
                    wr.addr = pend_idx_reg + IDX_W'(1);
                    wr.data = rd_data;
                end
                if (idx_reg > pos_m1)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_m1[IDX_W-1:0];
                    idx_next      = idx_m1;
                end
                else if (!pend_reg)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = pos_m1[IDX_W-1:0];
                    wr.data    = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DEL:
            begin
                // Keep elements outside the open range, compacted in order
                if (pend_reg && !in_range)
                begin
                    wr.en     = 1'b1;
                    wr.addr   = kept_reg[IDX_W-1:0];
                    wr.data   = rd_data;
                    kept_next = kept_reg + CNT_W'(1);
                end
                if (idx_reg != count_reg)
                begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    count_next = kept_reg;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        kept_reg      <= kept_next;
        pend_idx_reg  <= pend_idx_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        res_ok_reg    <= res_ok_next;
        res_rd_reg    <= res_rd_next;
        res_found_reg <= res_found_next;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_ok      <= res_ok_reg;
            read_value     <= res_rd_reg;
            found_position <= res_found_reg;
            list_length    <= count_reg;
        end
    end

endmodule

>>> verif/tb_positional_list_engine.sv
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A list image inside a
// small tracker class predicts each reply from the accepted request beats.
// The stimulus is a short directed pass over edge cases, then list-shaped
// random traffic under three backpressure mixes. It includes one long output
// hold while a fill burst is offered, and one pause that drains the engine.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;

    import ple_pkg::*;

    localparam int                 RAND_ITEMS_PER_PHASE = 320;
    localparam int                 RX_HOLD_CYCLES       = 400;
    localparam int                 WATCHDOG_LIMIT       = 3000;
    localparam int                 TAIL_CYCLES          = 64;
    localparam logic signed [31:0] INT_MIN              = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX              = 32'sh7fff_ffff;

    // Expected reply of one request
    typedef struct packed {
        logic        ok;
        logic [31:0] rd;
        logic [5:0]  found;
        logic [5:0]  len;
    } list_reply_t;

    // ------------------------------------------------------------------------
    // List image and queue of replies still owed by the engine
    // ------------------------------------------------------------------------
    class list_tracker;
        logic signed [31:0] elems [CAPACITY];
        int                 length;
        list_reply_t        pending_replies [$];
        int                 errors;

        function new();
            length = 0;
            errors = 0;
            foreach (elems[i])
                elems[i] = '0;
        endfunction

        // Apply one accepted request beat to the image and queue its reply
        function void take_request(logic [1:0] kind, logic [5:0] pos,
                                   logic signed [31:0] val, logic signed [31:0] lo,
                                   logic signed [31:0] hi);
            list_reply_t r;
            int          p;
            int          k;
            int          kept;
            r = '0;
            p = pos;
            case (kind)
                REQ_GET:
                begin
                    if (p >= 1 && p <= length)
                    begin
                        r.ok = 1'b1;
                        r.rd = elems[p-1];
                    end
                end
                REQ_FIND:
                begin
                    r.ok = 1'b1;
                    for (k = 0; k < length && r.found == 0; k++)
                        if (elems[k] == val)
                            r.found = 6'(k + 1);
                end
                REQ_INSERT:
                begin
                    if (p >= 1 && p <= length + 1 && length < CAPACITY)
                    begin
                        for (k = length; k > p - 1; k--)
                            elems[k] = elems[k-1];
                        elems[p-1] = val;
                        length++;
                        r.ok = 1'b1;
                    end
                end
                default:
                begin
                    // drop every element strictly inside (lo, hi), keep order
                    kept = 0;
                    for (k = 0; k < length; k++)
                    begin
                        if (!(lo < elems[k] && elems[k] < hi))
                        begin
                            elems[kept] = elems[k];
                            kept++;
                        end
                    end
                    length = kept;
                    r.ok   = 1'b1;
                end
            endcase
            r.len = 6'(length);
            pending_replies.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // Match one accepted reply beat against the oldest expectation
        function void check_reply(logic ok, logic signed [31:0] rd,
                                  logic [5:0] found, logic [5:0] len);
            list_reply_t want;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display({"%0t: unexpected reply, expected none, ",
                          "actual ok=%0b rd=%0h found=%0d len=%0d"},
                         $time, ok, rd, found, len);
                return;
            end
            want = pending_replies.pop_front();
            compare("status_ok", 32'(want.ok), 32'(ok));
            compare("read_value", want.rd, rd);
            compare("found_position", 32'(want.found), 32'(found));
            compare("list_length", 32'(want.len), 32'(len));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               status_ok;
    logic signed [31:0] read_value;
    logic [CNT_W-1:0]   found_position;
    logic [CNT_W-1:0]   list_length;

    list_tracker tracker = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int idle_cycles;

    positional_list_engine u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .position       (position),
        .value          (value),
        .range_low      (range_low),
        .range_high     (range_high),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status_ok      (status_ok),
        .read_value     (read_value),
        .found_position (found_position),
        .list_length    (list_length)
    );

    // Clock
    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Receiver: random backpressure plus long holds on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : receiver
        int hold_seen;
        int hold_left;
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: note request beats, check reply beats, watch for a hang
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            tracker.take_request(req_type, position, value, range_low, range_high);
        if (out_valid && out_ready)
            tracker.check_reply(status_ok, read_value, found_position, list_length);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_positional_list_engine: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one request beat after a random gap and hold it until accepted
    task automatic send_request(input logic [1:0] kind, input logic [5:0] pos,
                                input logic signed [31:0] val,
                                input logic signed [31:0] lo,
                                input logic signed [31:0] hi);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        position   <= pos;
        value      <= val;
        range_low  <= lo;
        range_high <= hi;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        @(negedge clk);
    endtask

    // Stop offering and wait for every owed reply
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (tracker.pending_replies.size() != 0)
            @(negedge clk);
    endtask

    // Small values collide often, so finds hit and ranges catch elements
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1, 2: return $signed($urandom_range(0, 16)) - 8;
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       return INT_MIN;
                    1:       return INT_MAX;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_stored_or_any();
        if (tracker.length > 0 && $urandom_range(0, 99) < 70)
            return tracker.elems[$urandom_range(0, tracker.length - 1)];
        return pick_value();
    endfunction

    // Insert at a valid slot most of the time, otherwise at a bad one
    task automatic send_insert();
        logic [5:0] pos;
        if ($urandom_range(0, 99) < 85)
            pos = 6'($urandom_range(1, tracker.length + 1));
        else if ($urandom_range(0, 1) == 0)
            pos = 6'd0;
        else
            pos = 6'($urandom_range(tracker.length + 2, 63));
        send_request(REQ_INSERT, pos, pick_value(), $urandom, $urandom);
    endtask

    // One random request shaped around the current list contents
    task automatic issue_random_request();
        logic [5:0]         pos;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] a;
        logic signed [31:0] b;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            send_insert();
        else if (pick < 58)
        begin
            if (tracker.length > 0 && $urandom_range(0, 99) < 80)
                pos = 6'($urandom_range(1, tracker.length));
            else
                pos = 6'($urandom_range(0, 63));
            send_request(REQ_GET, pos, $urandom, $urandom, $urandom);
        end
        else if (pick < 78)
            send_request(REQ_FIND, 6'($urandom_range(0, 63)), pick_stored_or_any(),
                         $urandom, $urandom);
        else
        begin
            a = $urandom;
            b = $urandom;
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    // empty range: low not below high
                    lo = (a > b) ? a : b;
                    hi = (a > b) ? b : a;
                end
                3, 4, 5, 6, 7, 8, 9, 10:
                begin
                    // narrow window around one stored or random value
                    a  = pick_stored_or_any();
                    lo = a - 1;
                    hi = a + 1;
                end
                11, 12, 13, 14, 15:
                begin
                    lo = $signed($urandom_range(0, 16)) - 10;
                    hi = lo + $signed($urandom_range(1, 8));
                end
                16:
                begin
                    lo = INT_MIN;
                    hi = INT_MAX;
                end
                default:
                begin
                    lo = a;
                    hi = b;
                end
            endcase
            send_request(REQ_DELETE, 6'($urandom_range(0, 63)), $urandom, lo, hi);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        int n;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        req_type      <= REQ_GET;
        position      <= '0;
        value         <= '0;
        range_low     <= '0;
        range_high    <= '0;
        send_idle_pct = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (phase = 0; phase < 3; phase++)
        begin
            // backpressure mix: slow receiver, then slow sender, then none
            case (phase)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct <= 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct <= 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase

            if (phase == 0)
            begin
                // empty list: failed get, find miss, delete of nothing
                send_request(REQ_GET,    6'd1,  32'sd0, 32'sd0, 32'sd0);
                send_request(REQ_FIND,   6'd0,  32'sd0, 32'sd0, 32'sd0);
                send_request(REQ_DELETE, 6'd0,  32'sd0, INT_MIN, INT_MAX);
                // bad insert slots, then head, tail and middle inserts, then one more bad slot
                send_request(REQ_INSERT, 6'd0,  32'sd5, 32'sd0, 32'sd0);
                send_request(REQ_INSERT, 6'd2,  32'sd5, 32'sd0, 32'sd0);
                send_request(REQ_INSERT, 6'd1,  INT_MAX, 32'sd0, 32'sd0);
                send_request(REQ_INSERT, 6'd1,  INT_MIN, 32'sd0, 32'sd0);
                send_request(REQ_INSERT, 6'd3,  32'sd0, 32'sd0, 32'sd0);
                send_request(REQ_INSERT, 6'd2,  -32'sd1, 32'sd0, 32'sd0);
                send_request(REQ_INSERT, 6'd5,  -32'sd1, 32'sd0, 32'sd0);
                send_request(REQ_INSERT, 6'd63, 32'sd7, 32'sd0, 32'sd0);
                // reads at both ends and out of range
                send_request(REQ_GET,    6'd1,  32'sd0, 32'sd0, 32'sd0);
                send_request(REQ_GET,    6'd5,  32'sd0, 32'sd0, 32'sd0);
                send_request(REQ_GET,    6'd6,  32'sd0, 32'sd0, 32'sd0);
                send_request(REQ_GET,    6'd0,  32'sd0, 32'sd0, 32'sd0);
                send_request(REQ_GET,    6'd63, 32'sd0, 32'sd0, 32'sd0);
                // first of duplicates, extreme value, absent value
                send_request(REQ_FIND,   6'd63, -32'sd1, 32'sd0, 32'sd0);
                send_request(REQ_FIND,   6'd0,  INT_MAX, 32'sd0, 32'sd0);
                send_request(REQ_FIND,   6'd0,  32'sd12345, 32'sd0, 32'sd0);
                // empty ranges, open bounds, extremes kept by the widest range
                send_request(REQ_DELETE, 6'd0,  32'sd0, 32'sd0, 32'sd0);
                send_request(REQ_DELETE, 6'd0,  32'sd0, INT_MAX, INT_MIN);
                send_request(REQ_DELETE, 6'd0,  32'sd0, -32'sd1, 32'sd0);
                send_request(REQ_DELETE, 6'd0,  32'sd0, -32'sd2, 32'sd1);
                send_request(REQ_DELETE, 6'd0,  32'sd0, INT_MIN, INT_MAX);
                send_request(REQ_GET,    6'd2,  32'sd0, 32'sd0, 32'sd0);
            end

            if (phase == 1)
            begin
                // drain fully, then hold the output while a fill burst is offered
                wait_for_drain();
                hold_requests <= hold_requests + 1;
                n = CAPACITY - tracker.length + 4;
                repeat (n)
                    send_request(REQ_INSERT, 6'($urandom_range(1, tracker.length + 1)),
                                 pick_value(), $urandom, $urandom);
            end

            repeat (RAND_ITEMS_PER_PHASE)
                issue_random_request();
        end

        // wait out every owed reply, then allow for a stray late beat
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_replies.size() == 0)
            $display("tb_positional_list_engine: clean");
        else
            $display("tb_positional_list_engine: errors");
        $finish;
    end

endmodule
